[hw/rtl/tsdf_pkg.sv]
package tsdf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int PRE_SLOTS     = 3;
    localparam int POS_TAB       = NUMBER_DIGITS;
    localparam int POS_LAST      = NUMBER_DIGITS + PRE_SLOTS + 1;
    localparam int POS_W         = $clog2(POS_LAST + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic                       num_en;
        bcd_t                       digits;
        logic [1:0]                 pre_len;
        logic [PRE_SLOTS-1:0][7:0]  pre;
        logic [7:0]                 ch;
    } cmd_t;

endpackage

[hw/rtl/tsdf_front.sv]
module tsdf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [7:0]                    data_byte,
    input  logic                          cfg_we,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output tsdf_pkg::cmd_t                q_cmd
);
    import tsdf_pkg::*;

    logic nb_reg, np_reg, se_reg, na_reg, sq_reg, st_reg;
    logic nb_next, np_next, se_next, na_next, sq_next, st_next;
    bcd_t count_reg, count_next;
    logic at_start_reg, at_start_next;
    logic blank_reg, blank_next;

    logic accept, emit, bump, is_nl, all_nine, carry;
    bcd_t count_inc;
    cmd_t cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && emit;
    assign q_cmd    = cmd;
    assign is_nl    = (data_byte == CH_NL);

    always_comb
    begin
        nb_next = nb_reg;
        np_next = np_reg;
        se_next = se_reg;
        na_next = na_reg;
        sq_next = sq_reg;
        st_next = st_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUMBER_NONBLANK:  nb_next = cfg_data;
                CFG_SHOW_NONPRINTING: np_next = cfg_data;
                CFG_SHOW_ENDS:        se_next = cfg_data;
                CFG_NUMBER_ALL:       na_next = cfg_data;
                CFG_SQUEEZE_BLANK:    sq_next = cfg_data;
                CFG_SHOW_TABS:        st_next = cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        all_nine  = 1'b1;
        carry     = 1'b1;
        count_inc = count_reg;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            all_nine = all_nine && (count_reg[i] == 4'd9);
        end
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            if (carry)
            begin
                if (count_reg[i] == 4'd9)
                begin
                    count_inc[i] = 4'd0;
                end
                else
                begin
                    count_inc[i] = count_reg[i] + 4'd1;
                    carry        = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        cmd.num_en    = 1'b0;
        cmd.digits    = count_reg;
        cmd.pre_len   = 2'd0;
        cmd.pre       = '0;
        cmd.ch        = data_byte;
        emit          = 1'b1;
        bump          = 1'b0;
        at_start_next = at_start_reg;
        blank_next    = blank_reg;
        if (op)
        begin
            emit          = !nb_reg && !np_reg && se_reg && !at_start_reg;
            cmd.ch        = CH_NL;
            at_start_next = 1'b1;
        end
        else
        begin
            if (nb_reg)
            begin
                if (at_start_reg && !is_nl)
                begin
                    cmd.num_en = 1'b1;
                    bump       = 1'b1;
                end
            end
            else if (np_reg)
            begin
                if (is_nl)
                begin
                    if (se_reg)
                    begin
                        cmd.pre_len = 2'd1;
                        cmd.pre[2]  = CH_DOLLAR;
                    end
                end
                else if (data_byte == CH_TAB)
                begin
                    if (st_reg)
                    begin
                        cmd.pre_len = 2'd1;
                        cmd.pre[2]  = CH_CARET;
                        cmd.ch      = CH_I;
                    end
                end
                else if (data_byte <= 8'd31)
                begin
                    cmd.pre_len = 2'd1;
                    cmd.pre[2]  = CH_CARET;
                    cmd.ch      = data_byte + 8'd64;
                end
                else if (data_byte == CH_DEL)
                begin
                    cmd.pre_len = 2'd1;
                    cmd.pre[2]  = CH_CARET;
                    cmd.ch      = CH_QMARK;
                end
                else if (data_byte >= 8'd160)
                begin
                    cmd.pre_len = 2'd2;
                    cmd.pre[1]  = CH_M;
                    cmd.pre[2]  = CH_DASH;
                    cmd.ch      = data_byte - 8'd128;
                end
                else if (data_byte >= 8'd128)
                begin
                    cmd.pre_len = 2'd3;
                    cmd.pre[0]  = CH_M;
                    cmd.pre[1]  = CH_DASH;
                    cmd.pre[2]  = CH_CARET;
                    cmd.ch      = data_byte - 8'd64;
                end
            end
            else if (se_reg)
            begin
                if (is_nl)
                begin
                    cmd.pre_len = 2'd1;
                    cmd.pre[2]  = CH_DOLLAR;
                end
            end
            else if (na_reg)
            begin
                if (at_start_reg)
                begin
                    cmd.num_en = 1'b1;
                    bump       = 1'b1;
                end
            end
            else if (sq_reg)
            begin
                if (at_start_reg && is_nl)
                begin
                    if (blank_reg)
                    begin
                        emit = 1'b0;
                    end
                    else
                    begin
                        blank_next = 1'b1;
                    end
                end
                else if (at_start_reg)
                begin
                    blank_next = 1'b0;
                end
            end
            else if (st_reg)
            begin
                if (data_byte == CH_TAB)
                begin
                    cmd.pre_len = 2'd1;
                    cmd.pre[2]  = CH_CARET;
                    cmd.ch      = CH_I;
                end
            end
            at_start_next = is_nl;
        end
        count_next = (bump && !all_nine) ? count_inc : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg       <= 1'b0;
            np_reg       <= 1'b0;
            se_reg       <= 1'b0;
            na_reg       <= 1'b0;
            sq_reg       <= 1'b0;
            st_reg       <= 1'b0;
            count_reg    <= bcd_t'(1) << (4 * (NUMBER_DIGITS - 1));
            at_start_reg <= 1'b1;
            blank_reg    <= 1'b0;
        end
        else
        begin
            nb_reg <= nb_next;
            np_reg <= np_next;
            se_reg <= se_next;
            na_reg <= na_next;
            sq_reg <= sq_next;
            st_reg <= st_next;
            if (accept)
            begin
                count_reg    <= count_next;
                at_start_reg <= at_start_next;
                blank_reg    <= blank_next;
            end
        end
    end

endmodule

[hw/rtl/tsdf_queue.sv]
module tsdf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsdf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output tsdf_pkg::cmd_t head_cmd
);
    import tsdf_pkg::*;

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/tsdf_back.sv]
module tsdf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  tsdf_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           last_of_run
);
    import tsdf_pkg::*;

    logic             busy_reg, busy_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;

    logic             load, emit, zero_run, is_last;
    logic [POS_W-1:0] cur_pos, body_pos;
    logic [7:0]       cur_byte;

    assign load     = !out_valid_reg || !out_stall;
    assign emit     = head_valid && load;
    assign body_pos = POS_W'(POS_LAST) - POS_W'(head_cmd.pre_len);
    assign cur_pos  = busy_reg ? pos_reg : (head_cmd.num_en ? '0 : body_pos);
    assign is_last  = (cur_pos == POS_W'(POS_LAST));
    assign pop      = emit && is_last;

    always_comb
    begin
        zero_run = 1'b1;
        cur_byte = head_cmd.ch;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            zero_run = zero_run && (head_cmd.digits[i] == 4'd0);
            if (cur_pos == POS_W'(i))
            begin
                cur_byte = (zero_run && (i != NUMBER_DIGITS - 1)) ? CH_SPACE
                         : {ASCII_DIGIT_HI, head_cmd.digits[i]};
            end
        end
        if (cur_pos == POS_W'(POS_TAB))
        begin
            cur_byte = CH_TAB;
        end
        for (int k = 0; k < PRE_SLOTS; k++)
        begin
            if (cur_pos == POS_W'(POS_TAB + 1 + k))
            begin
                cur_byte = head_cmd.pre[k];
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_byte_next = cur_byte;
            last_next     = is_last;
            busy_next     = !is_last;
            pos_next      = (cur_pos == POS_W'(POS_TAB)) ? body_pos : cur_pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

[hw/rtl/text_stream_display_filter.sv]
// Display filter for a text byte stream with the line numbering, squeezing, end marking,
// tab marking and caret/M- notation options of a cat utility; each input transfer carries
// one byte or an end-of-file mark, and each output transfer carries one formatted byte,
// with last_of_run set on the final byte caused by an input. The front end classifies an
// input combinationally and takes a new input every cycle while its four-entry command
// queue has room. The back end drives the single output byte port and emits one byte
// per cycle while a command is queued and out_stall is low. An input produces one byte
// for plain text, two to four for an escape, and eight (six digits, a tab and the byte)
// for a numbered line start. Inputs that produce nothing are not queued. Configuration
// writes are always accepted and must only be made while the block is idle.
module text_stream_display_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import tsdf_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_in_cmd, q_head_cmd;

    assign cfg_ready = 1'b1;

    tsdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in_cmd)
    );

    tsdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    tsdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_cmd    (q_head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
